>>> design/brf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brf_pkg
// Shared codes and types for the byte ring FIFO with line count.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_PULL = 2'd1;
    localparam logic [1:0] OP_LINE = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    // one result beat to load into the output register
    typedef struct packed {
        logic       load;
        logic       byte_valid;
        logic       last;
        logic       accepted;
        logic       line_complete;
        logic [7:0] stored_count;
        logic [7:0] line_count;
    } out_cmd_t;

endpackage
`default_nettype wire

>>> design/brf_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brf_out
// Burst buffer memory and result output register.
// ----------------------------------------------------------------------------
module brf_out #(
    parameter int MAX_BURST = 64,
    parameter int BIW       = 6
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire brf_pkg::out_cmd_t cmd,
    input  wire logic              bw_en,
    input  wire logic [BIW-1:0]    bw_addr,
    input  wire logic [7:0]        bw_data,
    input  wire logic [BIW-1:0]    br_addr,
    output logic                   out_free,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_out_byte,
    output logic                   m_byte_valid,
    output logic                   m_last,
    output logic                   m_accepted,
    output logic                   m_line_complete,
    output logic [7:0]             m_stored_count,
    output logic [7:0]             m_line_count
);

    logic [7:0] burst_mem [MAX_BURST];
    logic [7:0] rd_q_reg;
    logic       valid_reg;
    logic       byte_valid_reg;
    logic       last_reg;
    logic       accepted_reg;
    logic       line_complete_reg;
    logic [7:0] stored_reg;
    logic [7:0] lines_reg;

    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (bw_en) begin
            burst_mem[bw_addr] <= bw_data;
        end
        if (cmd.load && cmd.byte_valid) begin
            rd_q_reg <= burst_mem[br_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_valid_reg    <= cmd.byte_valid;
            last_reg          <= cmd.last;
            accepted_reg      <= cmd.accepted;
            line_complete_reg <= cmd.line_complete;
            stored_reg        <= cmd.stored_count;
            lines_reg         <= cmd.line_count;
        end
    end

    assign m_valid         = valid_reg;
    assign m_out_byte      = byte_valid_reg ? rd_q_reg : 8'd0;
    assign m_byte_valid    = byte_valid_reg;
    assign m_last          = last_reg;
    assign m_accepted      = accepted_reg;
    assign m_line_complete = line_complete_reg;
    assign m_stored_count  = stored_reg;
    assign m_line_count    = lines_reg;

endmodule
`default_nettype wire

>>> design/brf_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brf_core
// Ring memory, pointers, counts and the push / scan / emit sequencer.
// ----------------------------------------------------------------------------
module brf_core #(
    parameter int BUFFER_BYTES = 256,
    parameter int MAX_BURST    = 64,
    parameter int BIW          = 6
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_operation,
    input  wire logic [7:0]         s_data_byte,
    input  wire logic               s_first_of_group,
    input  wire logic [7:0]         s_group_length,
    input  wire logic [6:0]         s_max_bytes,
    input  wire logic               out_free,
    output brf_pkg::out_cmd_t       cmd,
    output logic                    bw_en,
    output logic [BIW-1:0]          bw_addr,
    output logic [7:0]              bw_data,
    output logic [BIW-1:0]          br_addr
);

    localparam int PW  = $clog2(BUFFER_BYTES);
    localparam int CW  = (PW > 8) ? PW : 8;
    localparam int BCW = $clog2(MAX_BURST + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [7:0]     ring_mem [BUFFER_BYTES];
    logic [7:0]     ring_q_reg;

    logic [1:0]     state_reg, state_next;
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]  iss_ptr_reg, iss_ptr_next;
    logic [PW-1:0]  held_reg, held_next;
    logic [PW-1:0]  nl_reg, nl_next;
    logic           grp_rej_reg, grp_rej_next;
    logic           is_line_reg, is_line_next;
    logic [BCW-1:0] lim_reg, lim_next;
    logic [BCW-1:0] iss_cnt_reg, iss_cnt_next;
    logic           pend_reg, pend_next;
    logic [BCW-1:0] bcnt_reg, bcnt_next;
    logic           line_done_reg, line_done_next;
    logic [BCW-1:0] e_idx_reg, e_idx_next;

    logic           ring_we;
    logic           ring_re;
    logic           accept;
    logic [PW-1:0]  free_bytes;
    logic           push_ok;
    logic [6:0]     lim_raw;
    logic [6:0]     lim7;
    logic           nothing;
    logic           can_issue;
    logic           stop_nl;
    logic           issue;
    logic           last_beat;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        return (p == PW'(BUFFER_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [7:0] sat8(input logic [PW-1:0] v);
        logic [CW-1:0] ext;
        ext = CW'(v);
        return (ext > CW'(255)) ? 8'd255 : ext[7:0];
    endfunction

    assign s_ready    = (state_reg == ST_IDLE) && out_free;
    assign accept     = s_valid && s_ready;
    assign free_bytes = PW'(BUFFER_BYTES - 1) - held_reg;

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[wr_ptr_reg] <= s_data_byte;
        end
        if (ring_re) begin
            ring_q_reg <= ring_mem[iss_ptr_reg];
        end
    end

    always_comb begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        iss_ptr_next   = iss_ptr_reg;
        held_next      = held_reg;
        nl_next        = nl_reg;
        grp_rej_next   = grp_rej_reg;
        is_line_next   = is_line_reg;
        lim_next       = lim_reg;
        iss_cnt_next   = iss_cnt_reg;
        pend_next      = pend_reg;
        bcnt_next      = bcnt_reg;
        line_done_next = line_done_reg;
        e_idx_next     = e_idx_reg;
        cmd            = '0;
        ring_we        = 1'b0;
        ring_re        = 1'b0;
        bw_en          = 1'b0;
        bw_addr        = bcnt_reg[BIW-1:0];
        bw_data        = ring_q_reg;
        br_addr        = e_idx_reg[BIW-1:0];
        push_ok        = 1'b0;
        can_issue      = 1'b0;
        stop_nl        = 1'b0;
        issue          = 1'b0;
        last_beat      = 1'b0;

        lim_raw = (s_operation == brf_pkg::OP_LINE) ? (s_max_bytes - 7'd1) : s_max_bytes;
        lim7    = (lim_raw > 7'(MAX_BURST)) ? 7'(MAX_BURST) : lim_raw;
        nothing = (lim7 == 7'd0) || (held_reg == '0) ||
                  ((s_operation == brf_pkg::OP_LINE) &&
                   ((nl_reg == '0) || (s_max_bytes == 7'd0)));

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_operation) inside
                        brf_pkg::OP_PUSH: begin
                            if (s_first_of_group) begin
                                grp_rej_next = CW'(s_group_length) > CW'(free_bytes);
                            end
                            push_ok = !grp_rej_next && (free_bytes != '0);
                            if (push_ok) begin
                                ring_we     = 1'b1;
                                wr_ptr_next = next_slot(wr_ptr_reg);
                                held_next   = held_reg + 1'b1;
                                if (s_data_byte == brf_pkg::NEWLINE_CHAR) begin
                                    nl_next = nl_reg + 1'b1;
                                end
                            end
                            cmd.load     = 1'b1;
                            cmd.last     = 1'b1;
                            cmd.accepted = push_ok;
                        end
                        brf_pkg::OP_PULL, brf_pkg::OP_LINE: begin
                            if (nothing) begin
                                cmd.load = 1'b1;
                                cmd.last = 1'b1;
                            end else begin
                                state_next     = ST_SCAN;
                                iss_ptr_next   = rd_ptr_reg;
                                iss_cnt_next   = '0;
                                pend_next      = 1'b0;
                                bcnt_next      = '0;
                                line_done_next = 1'b0;
                                lim_next       = lim7[BCW-1:0];
                                is_line_next   = (s_operation == brf_pkg::OP_LINE);
                            end
                        end
                        default: begin
                            cmd.load = 1'b1;
                            cmd.last = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                can_issue = (iss_cnt_reg != lim_reg) && (iss_ptr_reg != wr_ptr_reg);
                stop_nl   = pend_reg && is_line_reg && (ring_q_reg == brf_pkg::NEWLINE_CHAR);
                issue     = can_issue && !stop_nl;
                if (issue) begin
                    ring_re      = 1'b1;
                    iss_ptr_next = next_slot(iss_ptr_reg);
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                end
                if (pend_reg) begin
                    rd_ptr_next = next_slot(rd_ptr_reg);
                    held_next   = held_reg - 1'b1;
                    if (stop_nl) begin
                        nl_next        = nl_reg - 1'b1;
                        line_done_next = 1'b1;
                    end else begin
                        bw_en     = 1'b1;
                        bcnt_next = bcnt_reg + 1'b1;
                        if (!is_line_reg && (ring_q_reg == brf_pkg::NEWLINE_CHAR) &&
                            (nl_reg != '0)) begin
                            nl_next = nl_reg - 1'b1;
                        end
                    end
                end
                pend_next = issue;
                if (stop_nl || (!pend_reg && !can_issue)) begin
                    state_next = ST_EMIT;
                    pend_next  = 1'b0;
                    e_idx_next = '0;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.load = 1'b1;
                    if (bcnt_reg == '0) begin
                        cmd.last          = 1'b1;
                        cmd.line_complete = line_done_reg;
                        state_next        = ST_IDLE;
                    end else begin
                        last_beat         = (e_idx_reg == bcnt_reg - 1'b1);
                        cmd.byte_valid    = 1'b1;
                        cmd.last          = last_beat;
                        cmd.line_complete = last_beat && line_done_reg;
                        e_idx_next        = e_idx_reg + 1'b1;
                        if (last_beat) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        cmd.stored_count = sat8(held_next);
        cmd.line_count   = sat8(nl_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            held_reg      <= '0;
            nl_reg        <= '0;
            grp_rej_reg   <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            held_reg      <= held_next;
            nl_reg        <= nl_next;
            grp_rej_reg   <= grp_rej_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        iss_ptr_reg   <= iss_ptr_next;
        is_line_reg   <= is_line_next;
        lim_reg       <= lim_next;
        iss_cnt_reg   <= iss_cnt_next;
        bcnt_reg      <= bcnt_next;
        line_done_reg <= line_done_next;
        e_idx_reg     <= e_idx_next;
    end

endmodule
`default_nettype wire

>>> design/byte_ring_fifo_with_line_count_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_line_count_top
// Byte ring FIFO with a count of stored newlines; push, pull and get-line.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    operation, data_byte, first_of_group,
//                                   group_length, max_bytes
//  m_       out  m_valid/m_ready    out_byte, byte_valid, last, accepted,
//                                   line_complete, stored_count, line_count
//
//  Push and status-only items are answered from the idle state; back-to-back
//  pushes run at one beat per cycle while the output is free. A pull or
//  get-line reads the ring memory (registered read) into the burst buffer,
//  then gives one result beat per cycle out of the burst buffer while
//  m_ready holds, since every beat carries the counts after the whole step.
//  Items are taken one at a time. Reset clears pointers and counts at once.
//  m_ready low stalls the emit phase; s_ready falls while busy or blocked.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_line_count_top #(
    parameter int BUFFER_BYTES = 256,
    parameter int MAX_BURST    = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_operation,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_first_of_group,
    input  wire logic [7:0] s_group_length,
    input  wire logic [6:0] s_max_bytes,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_byte_valid,
    output logic            m_last,
    output logic            m_accepted,
    output logic            m_line_complete,
    output logic [7:0]      m_stored_count,
    output logic [7:0]      m_line_count
);

    localparam int BIW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;

    brf_pkg::out_cmd_t cmd;
    logic              out_free;
    logic              bw_en;
    logic [BIW-1:0]    bw_addr;
    logic [7:0]        bw_data;
    logic [BIW-1:0]    br_addr;

    brf_core #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_BURST    (MAX_BURST),
        .BIW          (BIW)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_data_byte      (s_data_byte),
        .s_first_of_group (s_first_of_group),
        .s_group_length   (s_group_length),
        .s_max_bytes      (s_max_bytes),
        .out_free         (out_free),
        .cmd              (cmd),
        .bw_en            (bw_en),
        .bw_addr          (bw_addr),
        .bw_data          (bw_data),
        .br_addr          (br_addr)
    );

    brf_out #(
        .MAX_BURST (MAX_BURST),
        .BIW       (BIW)
    ) u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .bw_en           (bw_en),
        .bw_addr         (bw_addr),
        .bw_data         (bw_data),
        .br_addr         (br_addr),
        .out_free        (out_free),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_last          (m_last),
        .m_accepted      (m_accepted),
        .m_line_complete (m_line_complete),
        .m_stored_count  (m_stored_count),
        .m_line_count    (m_line_count)
    );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the byte ring FIFO with line count. A queue of push, pull, get-line
// and no-op requests feeds a clocked driver. Each accepted request runs through
// a ring model kept in the bench, and the expected beats wait in a queue. A
// clocked monitor compares every output beat with the oldest expected beat.
// Both sides idle at random, and the receiver also holds off for one long stretch.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RING_SLOTS = 256;
    localparam int BURST_CAP  = 64;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       first;
        logic [7:0] glen;
        logic [6:0] maxb;
        logic       drain;
        logic       tight;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       accepted;
        logic       line_complete;
        logic [7:0] stored_count;
        logic [7:0] line_count;
    } beat_t;

    logic       aclk             = 1'b0;
    logic       aresetn          = 1'b0;
    logic       s_valid          = 1'b0;
    logic [1:0] s_operation      = brf_pkg::OP_NOP;
    logic [7:0] s_data_byte      = 8'd0;
    logic       s_first_of_group = 1'b0;
    logic [7:0] s_group_length   = 8'd0;
    logic [6:0] s_max_bytes      = 7'd0;
    logic       m_ready          = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_last;
    logic       m_accepted;
    logic       m_line_complete;
    logic [7:0] m_stored_count;
    logic [7:0] m_line_count;

    byte_ring_fifo_with_line_count_top #(
        .BUFFER_BYTES(RING_SLOTS),
        .MAX_BURST   (BURST_CAP)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_data_byte     (s_data_byte),
        .s_first_of_group(s_first_of_group),
        .s_group_length  (s_group_length),
        .s_max_bytes     (s_max_bytes),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_last          (m_last),
        .m_accepted      (m_accepted),
        .m_line_complete (m_line_complete),
        .m_stored_count  (m_stored_count),
        .m_line_count    (m_line_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ring model
    logic [7:0]  ring_mem [RING_SLOTS];
    int unsigned wr_ptr = 0;
    int unsigned rd_ptr = 0;
    int unsigned nl_held = 0;
    bit          grp_rej = 1'b0;

    req_t  pending_reqs[$];
    beat_t beats_due[$];
    req_t  cur;
    beat_t got;
    beat_t want;
    int    err_cnt = 0;
    int    gap_left = 0;
    int    hold_left = 0;
    int    cyc = 0;
    bit    long_done = 1'b0;
    bit    next_drain = 1'b0;
    bit    tight_mode = 1'b0;

    function automatic int unsigned ring_held();
        return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + RING_SLOTS - rd_ptr;
    endfunction

    function automatic int unsigned ring_free();
        return RING_SLOTS - 1 - ring_held();
    endfunction

    function automatic logic [7:0] sat8(input int unsigned v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic void ring_step(input req_t r);
        int unsigned lim;
        logic [7:0]  b;
        bit          line_done;
        beat_t       bt;
        beat_t       burst[$];
        lim = 0;
        line_done = 1'b0;
        case (r.op)
            brf_pkg::OP_PUSH: begin
                bt = '0;
                if (r.first)
                    grp_rej = (r.glen > ring_free());
                if (!grp_rej && ring_free() > 0) begin
                    ring_mem[wr_ptr] = r.data;
                    wr_ptr = (wr_ptr + 1) % RING_SLOTS;
                    if (r.data == brf_pkg::NEWLINE_CHAR)
                        nl_held++;
                    bt.accepted = 1'b1;
                end
                burst.push_back(bt);
            end
            brf_pkg::OP_PULL: begin
                lim = (r.maxb > BURST_CAP) ? BURST_CAP : r.maxb;
                while (lim > 0 && rd_ptr != wr_ptr) begin
                    b = ring_mem[rd_ptr];
                    if (b == brf_pkg::NEWLINE_CHAR && nl_held > 0)
                        nl_held--;
                    rd_ptr = (rd_ptr + 1) % RING_SLOTS;
                    bt = '0;
                    bt.out_byte = b;
                    bt.byte_valid = 1'b1;
                    burst.push_back(bt);
                    lim--;
                end
            end
            brf_pkg::OP_LINE: begin
                if (nl_held > 0 && r.maxb > 0) begin
                    lim = r.maxb - 1;
                    if (lim > BURST_CAP)
                        lim = BURST_CAP;
                    while (lim > 0 && rd_ptr != wr_ptr && !line_done) begin
                        b = ring_mem[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % RING_SLOTS;
                        if (b == brf_pkg::NEWLINE_CHAR) begin
                            nl_held--;
                            line_done = 1'b1;
                        end else begin
                            bt = '0;
                            bt.out_byte = b;
                            bt.byte_valid = 1'b1;
                            burst.push_back(bt);
                            lim--;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (burst.size() == 0)
            burst.push_back('0);
        for (int k = 0; k < burst.size(); k++) begin
            bt = burst[k];
            bt.stored_count = sat8(ring_held());
            bt.line_count = sat8(nl_held);
            if (k == burst.size() - 1) begin
                bt.last = 1'b1;
                bt.line_complete = line_done;
            end
            beats_due.push_back(bt);
        end
    endfunction

    function automatic int send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int recv_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic flag_beat(input string what, input beat_t g, input beat_t w);
        err_cnt++;
        if (err_cnt <= 50)
            $display({"%s: got byte=%h bv=%b last=%b acc=%b lc=%b cnt=%0d nl=%0d,",
                      " want byte=%h bv=%b last=%b acc=%b lc=%b cnt=%0d nl=%0d"},
                     what, g.out_byte, g.byte_valid, g.last, g.accepted, g.line_complete,
                     g.stored_count, g.line_count, w.out_byte, w.byte_valid, w.last,
                     w.accepted, w.line_complete, w.stored_count, w.line_count);
    endtask

    task automatic add_req(input logic [1:0] op, input logic [7:0] data,
                           input logic first, input logic [7:0] glen,
                           input logic [6:0] maxb);
        req_t r;
        r.op = op;
        r.data = data;
        r.first = first;
        r.glen = glen;
        r.maxb = maxb;
        r.drain = next_drain;
        r.tight = tight_mode;
        next_drain = 1'b0;
        pending_reqs.push_back(r);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready)
                ring_step(cur);
            if (s_valid && !s_ready) begin
            end else if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain && beats_due.size() > 0)) begin
                cur = pending_reqs.pop_front();
                s_operation <= cur.op;
                s_data_byte <= cur.data;
                s_first_of_group <= cur.first;
                s_group_length <= cur.glen;
                s_max_bytes <= cur.maxb;
                s_valid <= 1'b1;
                gap_left <= cur.tight ? 0 : send_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
            cyc <= 0;
            long_done <= 1'b0;
        end else begin
            cyc <= cyc + 1;
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!long_done && cyc > 300 && m_valid) begin
                m_ready <= 1'b0;
                hold_left <= 800;
                long_done <= 1'b1;
            end else if (cyc[10:9] != 2'd0 && $urandom_range(0, 99) < 15) begin
                m_ready <= 1'b0;
                hold_left <= recv_gap();
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got = {m_out_byte, m_byte_valid, m_last, m_accepted, m_line_complete,
                   m_stored_count, m_line_count};
            if (beats_due.size() == 0) begin
                flag_beat("unexpected beat", got, '0);
            end else begin
                want = beats_due.pop_front();
                if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                    got.last !== want.last || got.accepted !== want.accepted ||
                    got.line_complete !== want.line_complete ||
                    got.stored_count !== want.stored_count ||
                    got.line_count !== want.line_count)
                    flag_beat("beat mismatch", got, want);
            end
        end
    end

    initial begin
        int n_rand;
        int kind;
        int len;
        int glen;
        logic [7:0] b;
        n_rand = 0;

        // directed
        add_req(brf_pkg::OP_PULL, 8'h00, 1'b0, 8'd0, 7'd5);
        add_req(brf_pkg::OP_LINE, 8'h00, 1'b0, 8'd0, 7'd10);
        add_req(brf_pkg::OP_NOP, 8'hFF, 1'b1, 8'hFF, 7'd127);
        add_req(brf_pkg::OP_PUSH, 8'h00, 1'b1, 8'd4, 7'd0);
        add_req(brf_pkg::OP_PUSH, 8'hFF, 1'b0, 8'd0, 7'd0);
        add_req(brf_pkg::OP_PUSH, 8'h78, 1'b0, 8'd0, 7'd0);
        add_req(brf_pkg::OP_PUSH, brf_pkg::NEWLINE_CHAR, 1'b0, 8'd0, 7'd0);
        add_req(brf_pkg::OP_LINE, 8'h00, 1'b0, 8'd0, 7'd0);
        add_req(brf_pkg::OP_LINE, 8'h00, 1'b0, 8'd0, 7'd1);
        add_req(brf_pkg::OP_LINE, 8'h00, 1'b0, 8'd0, 7'd127);
        add_req(brf_pkg::OP_PUSH, brf_pkg::NEWLINE_CHAR, 1'b1, 8'd1, 7'd0);
        add_req(brf_pkg::OP_LINE, 8'h00, 1'b0, 8'd0, 7'd2);
        add_req(brf_pkg::OP_PUSH, 8'h41, 1'b1, 8'd2, 7'd0);
        add_req(brf_pkg::OP_PUSH, brf_pkg::NEWLINE_CHAR, 1'b0, 8'd0, 7'd0);
        add_req(brf_pkg::OP_PUSH, 8'h42, 1'b1, 8'd3, 7'd0);
        add_req(brf_pkg::OP_LINE, 8'h00, 1'b0, 8'd0, 7'd2);
        add_req(brf_pkg::OP_PUSH, 8'h43, 1'b1, 8'd255, 7'd0);
        add_req(brf_pkg::OP_PUSH, 8'h44, 1'b0, 8'd0, 7'd0);
        add_req(brf_pkg::OP_PUSH, 8'h45, 1'b1, 8'd0, 7'd0);
        add_req(brf_pkg::OP_PULL, 8'h00, 1'b0, 8'd0, 7'd127);
        add_req(brf_pkg::OP_PULL, 8'h00, 1'b0, 8'd0, 7'd64);

        // random
        while (n_rand < 350) begin
            tight_mode = ($urandom_range(0, 9) == 0);
            if (n_rand % 60 == 0)
                next_drain = 1'b1;
            kind = $urandom_range(0, 99);
            if (n_rand == 0 || (kind < 2 && n_rand < 250)) begin
                // fill the ring, then run past full
                glen = (n_rand == 0) ? 255 : $urandom_range(100, 255);
                for (int i = 0; i < glen + 3; i++) begin
                    b = ($urandom_range(0, 11) == 0) ? brf_pkg::NEWLINE_CHAR
                                                     : 8'($urandom_range(0, 255));
                    add_req(brf_pkg::OP_PUSH, b, i == 0, 8'(glen), 7'($urandom_range(0, 127)));
                end
                n_rand += glen + 3;
                add_req(brf_pkg::OP_PULL, 8'h00, 1'b0, 8'd0, 7'd100);
                n_rand++;
            end else if (kind < 45) begin
                len = $urandom_range(0, 20);
                glen = ($urandom_range(0, 99) < 85) ? len + 1 : $urandom_range(0, 255);
                for (int i = 0; i <= len; i++) begin
                    b = (i == len) ? brf_pkg::NEWLINE_CHAR : 8'($urandom_range(0, 255));
                    add_req(brf_pkg::OP_PUSH, b, i == 0,
                            (i == 0) ? 8'(glen) : 8'($urandom_range(0, 255)),
                            7'($urandom_range(0, 127)));
                end
                n_rand += len + 1;
            end else if (kind < 67) begin
                add_req(brf_pkg::OP_LINE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        8'($urandom_range(0, 255)),
                        ($urandom_range(0, 99) < 70) ? 7'($urandom_range(2, 40))
                                                     : 7'($urandom_range(0, 127)));
                n_rand++;
            end else if (kind < 85) begin
                add_req(brf_pkg::OP_PULL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        8'($urandom_range(0, 255)),
                        ($urandom_range(0, 99) < 70) ? 7'($urandom_range(1, 30))
                                                     : 7'($urandom_range(0, 127)));
                n_rand++;
            end else if (kind < 95) begin
                add_req(brf_pkg::OP_PUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
                n_rand++;
            end else begin
                add_req(brf_pkg::OP_NOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
                n_rand++;
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (pending_reqs.size() > 0 || s_valid || beats_due.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
design/brf_pkg.sv
design/brf_out.sv
design/brf_core.sv
design/byte_ring_fifo_with_line_count_top.sv
tb/tb_top.sv
